/* hw/rtl/nbs_pkg.sv */
// nbs_pkg: shared types, constants and helper functions of the noisy bump saturator
// no dependencies

package nbs_pkg;

   localparam int MUL_W   = 64;
   localparam int PROD_W  = 128;
   localparam int CNT_W   = 7;
   localparam int DIV_BITS = 36;
   localparam int DIVR_W  = 8;

   localparam logic [MUL_W-1:0] LIM62_U   = 64'h4000_0000_0000_0000;
   localparam logic [MUL_W-1:0] Q30_ONE   = 64'h0000_0000_4000_0000;
   localparam logic [30:0]      HALF_PI_Q30 = 31'd1686629716;
   localparam logic [16:0]      W_FULL    = 17'd65536;

   localparam logic [16:0] WRECK_RESET = 17'd0;
   localparam logic [28:0] BUMP_RESET  = 29'd42949673;
   localparam logic [31:0] HP_RESET    = 32'd394064967;
   localparam logic [31:0] SEED_RESET  = 32'd16386;

   localparam logic [1:0] CSR_WRECK = 2'd0;
   localparam logic [1:0] CSR_BUMP  = 2'd1;
   localparam logic [1:0] CSR_HP    = 2'd2;
   localparam logic [1:0] CSR_SEED  = 2'd3;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
      logic [CNT_W-1:0] iters;
   } mul_req_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIVR_W-1:0]   divisor;
   } div_req_type;

   // horner divisors of the sine series, innermost first
   function automatic logic [DIVR_W-1:0] horner_div(input logic [2:0] idx);
      logic [DIVR_W-1:0] d;
      case (idx)
         3'd0: d = 8'd156;
         3'd1: d = 8'd110;
         3'd2: d = 8'd72;
         3'd3: d = 8'd42;
         3'd4: d = 8'd20;
         3'd5: d = 8'd6;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   function automatic logic [MUL_W-1:0] mag64(input logic signed [MUL_W-1:0] v);
      return v[MUL_W-1] ? (~v + 64'd1) : v;
   endfunction

   // min(p >> s, 2^62)
   function automatic logic [MUL_W-1:0] shr_cap(input logic [PROD_W-1:0] p, input int s);
      logic [PROD_W-1:0] q;
      q = p >> s;
      if (q > {64'd0, LIM62_U})
         return LIM62_U;
      return q[MUL_W-1:0];
   endfunction

   // saturate a 65 bit sum into [-2^62, 2^62)
   function automatic logic signed [MUL_W-1:0] sat62(input logic signed [MUL_W:0] v);
      if ((v[64:62] == 3'b000) || (v[64:62] == 3'b111))
         return v[MUL_W-1:0];
      return v[64] ? 64'shC000_0000_0000_0000 : 64'sh3FFF_FFFF_FFFF_FFFF;
   endfunction

   // saturate a 65 bit sum into [-2^47, 2^47)
   function automatic logic signed [MUL_W-1:0] sat48(input logic signed [MUL_W:0] v);
      if ((v[64:47] == 18'h00000) || (v[64:47] == 18'h3FFFF))
         return v[MUL_W-1:0];
      return v[64] ? 64'shFFFF_8000_0000_0000 : 64'sh0000_7FFF_FFFF_FFFF;
   endfunction

endpackage

/* hw/rtl/noisy_bump_saturator.sv */
// noisy_bump_saturator: noisy head-bump saturator, one sample in, one sample out
// depends on nbs_pkg, nbs_noise, nbs_mul, nbs_div
//
// sequencing: each sample runs through the shared bit-serial multiplier (one multiplier bit
//   per cycle, 42 products at 26 highpass stages) and the serial divider (7 divisions)
// a new sample is taken only in idle, after the previous one is finished; a finished
//   sample waits in its output step while the previous result is still stalled
// reset: synchronous, clears control, integrators and highpass stages, loads the seed

module noisy_bump_saturator
   import nbs_pkg::*;
#(
   parameter int HP_STAGES   = 26,
   parameter int BUMP_PHASES = 3,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int PH_W     = $clog2(BUMP_PHASES + 1);
   localparam int PH_IDX_W = (BUMP_PHASES > 1) ? $clog2(BUMP_PHASES) : 1;
   localparam int HP_IDX_W = (HP_STAGES > 1) ? $clog2(HP_STAGES) : 1;
   localparam int SH_INJ   = SAMPLE_BITS - 9;
   localparam int SH_MIXUP = 32 - SAMPLE_BITS;
   localparam int SH_MIXDN = 48 - SAMPLE_BITS;

   // sequencer states
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_NOISE = 5'd1;
   localparam logic [4:0] ST_DIV6  = 5'd2;
   localparam logic [4:0] ST_NGAIN = 5'd3;
   localparam logic [4:0] ST_INJ   = 5'd4;
   localparam logic [4:0] ST_SQ    = 5'd5;
   localparam logic [4:0] ST_CUBE  = 5'd6;
   localparam logic [4:0] ST_TERM  = 5'd7;
   localparam logic [4:0] ST_SUMI  = 5'd8;
   localparam logic [4:0] ST_HPM   = 5'd9;
   localparam logic [4:0] ST_HPS   = 5'd10;
   localparam logic [4:0] ST_HPT   = 5'd11;
   localparam logic [4:0] ST_CORR  = 5'd12;
   localparam logic [4:0] ST_GAIN  = 5'd13;
   localparam logic [4:0] ST_XSQ   = 5'd14;
   localparam logic [4:0] ST_HMUL  = 5'd15;
   localparam logic [4:0] ST_HDIV  = 5'd16;
   localparam logic [4:0] ST_XP    = 5'd17;
   localparam logic [4:0] ST_WET   = 5'd18;
   localparam logic [4:0] ST_MIX   = 5'd19;
   localparam logic [4:0] ST_OUT   = 5'd20;

   // configuration registers
   logic [16:0] wreck_ff;
   logic [28:0] bump_ff;
   logic [31:0] hpc_ff;

   // control
   logic [4:0]          state_ff, state_in;
   logic                wait_ff, wait_in;
   logic [2:0]          step_ff, step_in;
   logic [HP_IDX_W-1:0] hp_idx_ff, hp_idx_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [34:0]                   sum_ff, sum_in;
   logic [31:0]                   n_ff, n_in;
   logic signed [63:0]            v_ff, v_in;
   logic [63:0]                   tmp_ff, tmp_in;
   logic signed [63:0]            hb_ff, hb_in;
   logic signed [63:0]            t_ff, t_in;
   logic signed [63:0]            corr_ff, corr_in;
   logic [30:0]                   xs_ff, xs_in;
   logic [63:0]                   x2_ff, x2_in;
   logic [30:0]                   p_ff, p_in;
   logic signed [63:0]            wet_ff, wet_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;

   // state stores
   logic signed [47:0] integ_ff [BUMP_PHASES];
   logic signed [63:0] hp_ff [HP_STAGES];
   logic               integ_we;
   logic               hp_we;
   logic signed [63:0] integ_wdata;
   logic signed [63:0] hp_wdata;

   // shared units
   mul_req_type       mul_req;
   div_req_type       div_req;
   logic              mul_done;
   logic              div_done;
   logic [PROD_W-1:0] prod;
   logic [DIV_BITS-1:0] quo;
   logic [31:0]       noise_q;
   logic [31:0]       noise_next;
   logic              noise_step;
   logic              seed_load;

   // helpers
   logic                req_xfer;
   logic                rsp_xfer;
   logic [PH_W-1:0]     phase_m1;
   logic [PH_IDX_W-1:0] ph_idx;
   logic signed [63:0]  x_ext;
   logic [63:0]         x_mag;
   logic [63:0]         v_mag;
   logic signed [63:0]  integ_cur;
   logic signed [63:0]  hp_cur;
   logic signed [63:0]  inj;
   logic [63:0]         inj_mag;
   logic signed [63:0]  term_s;
   logic [63:0]         cap_r;
   logic signed [63:0]  diff;
   logic signed [63:0]  hb_sum;
   logic [63:0]         hb_mag_sh;
   logic [30:0]         xs_now;
   logic [16:0]         gain_k;
   logic [16:0]         dry_k;
   logic signed [63:0]  dry;
   logic signed [63:0]  mix;
   logic signed [63:0]  mix_sh;
   logic [63:0]         wet_mag;
   logic [31:0]         q_hdiv;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = out_ff;
   assign seed_load = csr_we && (csr_index == CSR_SEED);

   nbs_noise u_noise (
      .clock     (clock),
      .reset     (reset),
      .seed_load (seed_load),
      .seed      (csr_wdata),
      .step      (noise_step),
      .state_q   (noise_q),
      .next_q    (noise_next)
   );

   nbs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (prod)
   );

   nbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (quo)
   );

   // configuration writes, wreck held at full effect
   always_ff @(posedge clock) begin
      if (reset) begin
         wreck_ff <= WRECK_RESET;
         bump_ff  <= BUMP_RESET;
         hpc_ff   <= HP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WRECK: wreck_ff <= (csr_wdata[16:0] > W_FULL) ? W_FULL : csr_wdata[16:0];
            CSR_BUMP:  bump_ff  <= csr_wdata[28:0];
            CSR_HP:    hpc_ff   <= csr_wdata;
            CSR_SEED:  ;
            default:   ;
         endcase
      end
   end

   // operand selection and shared derived values
   always_comb begin
      phase_m1  = phase_ff - 1'b1;
      ph_idx    = phase_m1[PH_IDX_W-1:0];
      integ_cur = 64'(integ_ff[ph_idx]);
      hp_cur    = hp_ff[hp_idx_ff];
      x_ext     = 64'(x_ff);
      x_mag     = mag64(x_ext);
      v_mag     = mag64(v_ff);
      diff      = t_ff - hp_cur;
      hb_mag_sh = mag64(hb_ff) >> 18;
      xs_now    = (hb_mag_sh > {33'd0, HALF_PI_Q30}) ? HALF_PI_Q30 : hb_mag_sh[30:0];
      gain_k    = W_FULL - {1'b0, wreck_ff[16:1]};
      dry_k     = W_FULL - wreck_ff;

      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      mul_req.iters = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      case (state_ff)
         ST_DIV6: begin
            div_req.start    = !wait_ff;
            div_req.dividend = {1'b0, sum_ff};
            div_req.divisor  = 8'd6;
         end
         ST_NGAIN: begin
            mul_req.start = !wait_ff;
            mul_req.a     = {28'd0, quo};
            mul_req.b     = {47'd0, wreck_ff};
            mul_req.iters = 7'd17;
         end
         ST_INJ: begin
            mul_req.start = !wait_ff;
            mul_req.a     = x_mag;
            mul_req.b     = {32'd0, n_ff};
            mul_req.iters = 7'd32;
         end
         ST_SQ: begin
            mul_req.start = !wait_ff;
            mul_req.a     = v_mag;
            mul_req.b     = v_mag;
            mul_req.iters = 7'd48;
         end
         ST_CUBE: begin
            mul_req.start = !wait_ff;
            mul_req.a     = tmp_ff;
            mul_req.b     = v_mag;
            mul_req.iters = 7'd48;
         end
         ST_TERM: begin
            mul_req.start = !wait_ff;
            mul_req.a     = tmp_ff;
            mul_req.b     = {35'd0, bump_ff};
            mul_req.iters = 7'd29;
         end
         ST_HPM: begin
            mul_req.start = !wait_ff;
            mul_req.a     = mag64(diff);
            mul_req.b     = {32'd0, hpc_ff};
            mul_req.iters = 7'd32;
         end
         ST_GAIN: begin
            mul_req.start = !wait_ff;
            mul_req.a     = mag64(hb_ff);
            mul_req.b     = {47'd0, gain_k};
            mul_req.iters = 7'd17;
         end
         ST_XSQ: begin
            mul_req.start = !wait_ff;
            mul_req.a     = {33'd0, xs_now};
            mul_req.b     = {33'd0, xs_now};
            mul_req.iters = 7'd31;
         end
         ST_HMUL: begin
            mul_req.start = !wait_ff;
            mul_req.a     = x2_ff;
            mul_req.b     = {33'd0, p_ff};
            mul_req.iters = 7'd31;
         end
         ST_HDIV: begin
            div_req.start    = !wait_ff;
            div_req.dividend = tmp_ff[DIV_BITS-1:0];
            div_req.divisor  = horner_div(step_ff);
         end
         ST_XP: begin
            mul_req.start = !wait_ff;
            mul_req.a     = {33'd0, xs_ff};
            mul_req.b     = {33'd0, p_ff};
            mul_req.iters = 7'd31;
         end
         ST_WET: begin
            mul_req.start = !wait_ff;
            mul_req.a     = tmp_ff;
            mul_req.b     = {47'd0, wreck_ff};
            mul_req.iters = 7'd17;
         end
         ST_MIX: begin
            mul_req.start = !wait_ff;
            mul_req.a     = x_mag;
            mul_req.b     = {47'd0, dry_k};
            mul_req.iters = 7'd17;
         end
         default: ;
      endcase
   end

   // sequencer and datapath updates
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      step_in      = step_ff;
      hp_idx_in    = hp_idx_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      x_in    = x_ff;
      sum_in  = sum_ff;
      n_in    = n_ff;
      v_in    = v_ff;
      tmp_in  = tmp_ff;
      hb_in   = hb_ff;
      t_in    = t_ff;
      corr_in = corr_ff;
      xs_in   = xs_ff;
      x2_in   = x2_ff;
      p_in    = p_ff;
      wet_in  = wet_ff;
      out_in  = out_ff;
      noise_step  = 1'b0;
      integ_we    = 1'b0;
      hp_we       = 1'b0;
      integ_wdata = '0;
      hp_wdata    = sat62(65'(hp_cur) + 65'($signed(tmp_ff)));

      // integrator injection, floor of signed product over 2^SH_INJ
      inj_mag = prod[63:0] >> SH_INJ;
      if (x_ff < 0)
         inj = -$signed(inj_mag + {63'd0, (prod[SH_INJ-1:0] != '0)});
      else
         inj = $signed(inj_mag);

      cap_r  = '0;
      term_s = '0;

      hb_sum = '0;
      for (int i = 0; i < BUMP_PHASES; i++)
         hb_sum = hb_sum + 64'(integ_ff[i]);

      dry    = x_ff < 0 ? -$signed(prod[63:0] << SH_MIXUP) : $signed(prod[63:0] << SH_MIXUP);
      mix    = dry + wet_ff;
      mix_sh = mix >>> SH_MIXDN;
      wet_mag = {prod[62:0], 1'b0};
      q_hdiv  = quo[31:0];

      if (state_ff != ST_IDLE && state_ff != ST_NOISE && state_ff != ST_SUMI &&
          state_ff != ST_HPS && state_ff != ST_HPT && state_ff != ST_CORR &&
          state_ff != ST_OUT && !wait_ff)
         wait_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_in     = req_sample_in;
               sum_in   = {3'd0, noise_q};
               step_in  = '0;
               state_in = ST_NOISE;
            end
         end
         ST_NOISE: begin
            // five generator steps, each new value added to the running sum
            noise_step = 1'b1;
            sum_in     = sum_ff + {3'd0, noise_next};
            step_in    = step_ff + 3'd1;
            if (step_ff == 3'd4)
               state_in = ST_DIV6;
         end
         ST_DIV6: begin
            if (wait_ff && div_done) begin
               wait_in  = 1'b0;
               state_in = ST_NGAIN;
            end
         end
         ST_NGAIN: begin
            if (wait_ff && mul_done) begin
               n_in     = prod[47:16];
               wait_in  = 1'b0;
               state_in = ST_INJ;
            end
         end
         ST_INJ: begin
            if (wait_ff && mul_done) begin
               v_in     = sat48(65'(integ_cur) + 65'(inj));
               wait_in  = 1'b0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (wait_ff && mul_done) begin
               tmp_in   = shr_cap(prod, 40);
               wait_in  = 1'b0;
               state_in = ST_CUBE;
            end
         end
         ST_CUBE: begin
            if (wait_ff && mul_done) begin
               tmp_in   = shr_cap(prod, 40);
               wait_in  = 1'b0;
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (wait_ff && mul_done) begin
               cap_r  = shr_cap(prod, 32);
               term_s = $signed(cap_r);
               // cubic leak pulls the integrator toward zero
               if (v_ff < 0)
                  integ_wdata = sat48(65'(v_ff) + 65'(term_s));
               else
                  integ_wdata = sat48(65'(v_ff) - 65'(term_s));
               integ_we = 1'b1;
               if (phase_ff >= PH_W'(BUMP_PHASES))
                  phase_in = PH_W'(1);
               else
                  phase_in = phase_ff + 1'b1;
               wait_in  = 1'b0;
               state_in = ST_SUMI;
            end
         end
         ST_SUMI: begin
            hb_in     = hb_sum <<< 8;
            t_in      = hb_sum <<< 8;
            corr_in   = '0;
            hp_idx_in = '0;
            state_in  = ST_HPM;
         end
         ST_HPM: begin
            if (wait_ff && mul_done) begin
               cap_r    = shr_cap(prod, 48);
               tmp_in   = diff < 0 ? 64'(-$signed(cap_r)) : cap_r;
               wait_in  = 1'b0;
               state_in = ST_HPS;
            end
         end
         ST_HPS: begin
            hp_we    = 1'b1;
            tmp_in   = hp_wdata;
            state_in = ST_HPT;
         end
         ST_HPT: begin
            t_in    = sat62(65'(t_ff) - 65'($signed(tmp_ff)));
            corr_in = sat62(65'(corr_ff) + 65'($signed(tmp_ff)));
            if (hp_idx_ff == HP_IDX_W'(HP_STAGES - 1)) begin
               state_in = ST_CORR;
            end else begin
               hp_idx_in = hp_idx_ff + 1'b1;
               state_in  = ST_HPM;
            end
         end
         ST_CORR: begin
            hb_in    = sat62(65'(hb_ff) - 65'(corr_ff));
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            if (wait_ff && mul_done) begin
               cap_r    = shr_cap(prod, 16);
               hb_in    = hb_ff < 0 ? -$signed(cap_r) : $signed(cap_r);
               wait_in  = 1'b0;
               state_in = ST_XSQ;
            end
         end
         ST_XSQ: begin
            if (!wait_ff)
               xs_in = xs_now;
            if (wait_ff && mul_done) begin
               x2_in    = shr_cap(prod, 30);
               p_in     = Q30_ONE[30:0];
               step_in  = '0;
               wait_in  = 1'b0;
               state_in = ST_HMUL;
            end
         end
         ST_HMUL: begin
            if (wait_ff && mul_done) begin
               tmp_in   = shr_cap(prod, 30);
               wait_in  = 1'b0;
               state_in = ST_HDIV;
            end
         end
         ST_HDIV: begin
            if (wait_ff && div_done) begin
               p_in    = 31'(Q30_ONE[31:0] - q_hdiv);
               wait_in = 1'b0;
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd5)
                  state_in = ST_XP;
               else
                  state_in = ST_HMUL;
            end
         end
         ST_XP: begin
            if (wait_ff && mul_done) begin
               cap_r    = shr_cap(prod, 30);
               tmp_in   = (cap_r > Q30_ONE) ? Q30_ONE : cap_r;
               wait_in  = 1'b0;
               state_in = ST_WET;
            end
         end
         ST_WET: begin
            if (wait_ff && mul_done) begin
               // wet takes the sign of the gained signal, negative unless strictly positive
               if (!hb_ff[63] && (hb_ff != 0))
                  wet_in = $signed(wet_mag);
               else
                  wet_in = -$signed(wet_mag);
               wait_in  = 1'b0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // saturated sample parked in tmp until the output register is free
            if (wait_ff && mul_done) begin
               if ((mix_sh[63:SAMPLE_BITS-1] == '0) || (mix_sh[63:SAMPLE_BITS-1] == '1))
                  tmp_in = 64'(mix_sh[SAMPLE_BITS-1:0]);
               else if (mix_sh[63])
                  tmp_in = 64'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
               else
                  tmp_in = 64'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
               wait_in  = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in       = tmp_ff[SAMPLE_BITS-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            wait_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         step_ff      <= '0;
         hp_idx_ff    <= '0;
         phase_ff     <= PH_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         step_ff      <= step_in;
         hp_idx_ff    <= hp_idx_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff    <= x_in;
      sum_ff  <= sum_in;
      n_ff    <= n_in;
      v_ff    <= v_in;
      tmp_ff  <= tmp_in;
      hb_ff   <= hb_in;
      t_ff    <= t_in;
      corr_ff <= corr_in;
      xs_ff   <= xs_in;
      x2_ff   <= x2_in;
      p_ff    <= p_in;
      wet_ff  <= wet_in;
      out_ff  <= out_in;
   end

   // integrators and highpass stages, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUMP_PHASES; i++)
            integ_ff[i] <= '0;
         for (int j = 0; j < HP_STAGES; j++)
            hp_ff[j] <= '0;
      end else begin
         if (integ_we)
            integ_ff[ph_idx] <= integ_wdata[47:0];
         if (hp_we)
            hp_ff[hp_idx_ff] <= hp_wdata;
      end
   end

endmodule

/* hw/rtl/nbs_noise.sv */
// nbs_noise: 32 bit xorshift generator, one step per cycle on request
// depends on nbs_pkg

module nbs_noise
   import nbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        seed_load,
   input  logic [31:0] seed,
   input  logic        step,
   output logic [31:0] state_q,
   output logic [31:0] next_q
);

   logic [31:0] gen_ff;
   logic [31:0] gen_in;
   logic [31:0] s1;
   logic [31:0] s2;

   always_comb begin
      s1 = gen_ff ^ (gen_ff << 13);
      s2 = s1 ^ (s1 >> 17);
      next_q = s2 ^ (s2 << 5);
      gen_in = gen_ff;
      if (seed_load)
         gen_in = seed;
      else if (step)
         gen_in = next_q;
   end

   always_ff @(posedge clock) begin
      if (reset)
         gen_ff <= SEED_RESET;
      else
         gen_ff <= gen_in;
   end

   assign state_q = gen_ff;

endmodule

/* hw/rtl/nbs_mul.sv */
// nbs_mul: bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
// depends on nbs_pkg

module nbs_mul
   import nbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mul_req_type       req,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [MUL_W-1:0]  a_ff, a_in;
   logic [MUL_W-1:0]  b_ff, b_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  bit_pos;
   logic              b_bit;

   always_comb begin
      bit_pos = cnt_ff - 7'd1;
      b_bit   = b_ff[bit_pos[5:0]];
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
         cnt_in  = req.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << 1) + (b_bit ? {64'd0, a_ff} : {PROD_W{1'b0}});
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* hw/rtl/nbs_div.sv */
// nbs_div: restoring divider by a small divisor, one quotient bit per cycle
// depends on nbs_pkg

module nbs_div
   import nbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_req_type         req,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient
);

   logic [DIV_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DIVR_W-1:0]   dvs_ff, dvs_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIVR_W:0]     rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_BITS-1]};
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = 8'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVR_W-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/nbs_checker.sv */
// nbs_checker: port level checks of the noisy bump saturator, bound to the top level
// depends on noisy_bump_saturator

module nbs_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled result changed");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   // one item in flight: an accepted transfer closes the input
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a transfer");

   // no result appears in the cycle after a transfer
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind noisy_bump_saturator nbs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_nbs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

/* tb/tb_top.sv */
// tb_top: self-checking testbench of noisy_bump_saturator, directed table then random samples
// depends on nbs_pkg and the noisy_bump_saturator rtl
`timescale 1ns / 100ps

module tb_top
   import nbs_pkg::*;
;

   localparam longint LIM62 = 64'sh4000_0000_0000_0000;
   localparam longint LIM48 = 64'sh0000_8000_0000_0000;
   localparam longint LIM24 = 64'sh0000_0000_0080_0000;
   localparam longint unsigned HALF_PI = 64'd1686629716;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int HOLD_CYCLES = 6000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_WRECK;
   logic [31:0] csr_wdata = '0;

   noisy_bump_saturator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor state, a private copy of the block ----------------
   logic [16:0] p_wreck;
   logic [28:0] p_bump;
   logic [31:0] p_hp;
   logic [31:0] p_noise;
   int          p_phase;
   longint      p_integ [3];
   longint      p_stage [26];

   logic signed [23:0] expected_samples[$];
   int mismatches = 0;
   int sent_count = 0;
   int idle_cycles = 0;

   // min(floor(a*b / 2^s), 2^62)
   function automatic longint unsigned mul_trunc(longint unsigned a, longint unsigned b, int s);
      logic [127:0] prod;
      logic [127:0] q;
      prod = {64'd0, a} * {64'd0, b};
      q = prod >> s;
      if (q > 128'(LIM62))
         return LIM62;
      return q[63:0];
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   // signed times unsigned over 2^s, toward zero
   function automatic longint scale_tz(longint a, longint unsigned b, int s);
      longint r;
      r = longint'(mul_trunc(magnitude(a), b, s));
      return a < 0 ? -r : r;
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v >= lim) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [31:0] xorshift_step(logic [31:0] x);
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   // truncated taylor sine in q2.30, capped at one
   function automatic longint unsigned sine_q30(longint unsigned xv);
      longint unsigned x2, p;
      longint unsigned divs [6];
      divs = '{156, 110, 72, 42, 20, 6};
      x2 = (xv * xv) >> 30;
      p = ONE_Q30;
      for (int i = 0; i < 6; i++)
         p = ONE_Q30 - ((x2 * p) >> 30) / divs[i];
      p = (xv * p) >> 30;
      return p > ONE_Q30 ? ONE_Q30 : p;
   endfunction

   task automatic clear_predictor();
      p_wreck = WRECK_RESET;
      p_bump = BUMP_RESET;
      p_hp = HP_RESET;
      p_noise = SEED_RESET;
      p_phase = 1;
      foreach (p_integ[i]) p_integ[i] = 0;
      foreach (p_stage[i]) p_stage[i] = 0;
   endtask

   // one sample through the saturator, advancing predictor state
   function automatic logic signed [23:0] saturate_sample(logic signed [23:0] s);
      longint x, v, term, hb, t, corr, st, wet, mix;
      longint unsigned w, sum, n, m, sq, cube, xm, sn;
      logic [31:0] r;
      x = s;
      w = p_wreck;
      r = p_noise;
      sum = r;
      for (int i = 0; i < 5; i++) begin
         r = xorshift_step(r);
         sum += r;
      end
      p_noise = r;
      n = ((sum / 6) * w) >> 16;
      // rotating integrator: noise injection then cubic leak
      v = p_integ[p_phase - 1];
      v = clamp(v + ((x * longint'(n)) >>> 15), LIM48);
      m = magnitude(v);
      sq = mul_trunc(m, m, 40);
      cube = mul_trunc(sq, m, 40);
      term = longint'(mul_trunc(cube, 64'(p_bump), 32));
      v = clamp(v < 0 ? v + term : v - term, LIM48);
      p_integ[p_phase - 1] = v;
      p_phase = (p_phase >= 3) ? 1 : p_phase + 1;
      hb = (p_integ[0] + p_integ[1] + p_integ[2]) * 256;
      // highpass chain, summed stage outputs become the correction
      t = hb;
      corr = 0;
      for (int i = 0; i < 26; i++) begin
         st = clamp(p_stage[i] + scale_tz(t - p_stage[i], 64'(p_hp), 48), LIM62);
         p_stage[i] = st;
         t = clamp(t - st, LIM62);
         corr = clamp(corr + st, LIM62);
      end
      hb = clamp(hb - corr, LIM62);
      hb = scale_tz(hb, 64'd65536 - w / 2, 16);
      xm = magnitude(hb) >> 18;
      if (xm > HALF_PI) xm = HALF_PI;
      sn = sine_q30(xm);
      wet = longint'(sn * w) * 2;
      if (!(hb > 0)) wet = -wet;
      mix = x * longint'(64'd65536 - w) * 256 + wet;
      mix = clamp(mix >>> 24, LIM24);
      return mix[23:0];
   endfunction

   // one register write with csr_we dropped again before returning, so back to back writes never overlap
   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WRECK: p_wreck = (data[16:0] > W_FULL) ? W_FULL : data[16:0];
         CSR_BUMP:  p_bump = data[28:0];
         CSR_HP:    p_hp = data;
         CSR_SEED:  p_noise = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // settle until every expected sample is back before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic bit calm_window();
      return sent_count >= 500 && sent_count < 700;
   endfunction

   // offer one sample and wait for its transfer
   task automatic send_sample(logic signed [23:0] s, bit typed, logic signed [23:0] typed_out);
      logic signed [23:0] predicted;
      while (!calm_window() && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = saturate_sample(s);
      expected_samples.push_back(typed ? typed_out : predicted);
      sent_count++;
   endtask

   function automatic logic signed [23:0] random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return 24'sh7FFFFF;
      if (pick < 16) return 24'sh800000;
      if (pick < 40) return 24'($signed($urandom_range(510)) - 255);
      return 24'($urandom);
   endfunction

   // directed table: either a register write or a sample with optional typed expectation
   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;
      logic [31:0] data;
      logic signed [23:0] sample;
      bit          typed;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic void add_sample(logic signed [23:0] s, bit typed);
      directed_rows.push_back('{1'b0, CSR_WRECK, 32'd0, s, typed});
   endfunction

   function automatic void add_csr(logic [1:0] idx, logic [31:0] data);
      directed_rows.push_back('{1'b1, idx, data, 24'sd0, 1'b0});
   endfunction

   // ---------------- main stimulus ----------------
   initial begin
      logic [31:0] wr, bp, hp, sd;
      clear_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wreck zero after reset: output equals input exactly
      add_sample(24'sd0, 1'b1);
      add_sample(24'sd1, 1'b1);
      add_sample(-24'sd1, 1'b1);
      add_sample(24'sh7FFFFF, 1'b1);
      add_sample(24'sh800000, 1'b1);
      add_sample(24'sh555555, 1'b1);
      add_sample(24'shAAAAAA, 1'b1);
      // wreck above full scale is held at full scale
      add_csr(CSR_WRECK, 32'd131071);
      add_sample(24'sd0, 1'b0);
      add_sample(24'sd1, 1'b0);
      add_sample(-24'sd1, 1'b0);
      add_sample(24'sh7FFFFF, 1'b0);
      add_sample(24'sh800000, 1'b0);
      // zero seed gives zero noise
      add_csr(CSR_SEED, 32'd0);
      add_sample(24'sh7FFFFF, 1'b0);
      add_sample(24'sh400000, 1'b0);
      // strong leak (bump 2^28) and fast highpass (coefficient 2^31)
      add_csr(CSR_SEED, 32'hFFFF_FFFF);
      add_csr(CSR_BUMP, 32'd268435456);
      add_csr(CSR_HP, 32'h8000_0000);
      add_sample(24'sh7FFFFF, 1'b0);
      add_sample(24'sh7FFFFF, 1'b0);
      add_sample(24'sh800000, 1'b0);
      add_csr(CSR_HP, 32'd0);
      add_sample(24'sh123456, 1'b0);
      add_sample(-24'sd3, 1'b0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_drained();
            write_csr(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].sample);
         end
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin wr = 0;      bp = 0;         hp = 0;            sd = 32'hFFFF_FFFF; end
            1: begin wr = 65536;  bp = 268435456; hp = 32'h8000_0000; sd = $urandom; end
            2: begin
               wr = $urandom_range(131071); bp = $urandom_range(268435456);
               hp = $urandom; sd = $urandom;
            end
            3: begin wr = 32768;  bp = BUMP_RESET; hp = HP_RESET;  sd = SEED_RESET; end
            default: begin
               wr = 100000; bp = $urandom_range(268435456); hp = $urandom_range(4000000000);
               sd = 32'd16386;
            end
         endcase
         wait_drained();
         write_csr(CSR_WRECK, wr);
         write_csr(CSR_BUMP, bp);
         write_csr(CSR_HP, hp);
         write_csr(CSR_SEED, sd);
         for (int k = 0; k < 335; k++) begin
            send_sample(random_sample(), 1'b0, 24'sd0);
            // once, stop and let the block drain completely
            if (ph == 2 && k == 100) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (expected_samples.size() != 0) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;

      while (expected_samples.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (mismatches == 0 && expected_samples.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // ---------------- result side: stall pattern and checking ----------------
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      logic signed [23:0] want;
      if (rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: sample_out %0d", rsp_sample_out);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_out !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample_out mismatch: expected %0d actual %0d", want, rsp_sample_out);
            end
         end
      end
      // long receiver hold-off so the block fills and stalls its input
      if (!hold_done && sent_count >= 1000) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm_window() && ($urandom_range(99) < 31);
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
